// ===== hw/rtl/gbls_pkg.sv =====
// ----------------------------------------------------------------------------
// gbls_pkg: shared types and constants of the blur and sharpen block
// Controller states, command and status bundles, register indexes, reset
// values and the small lookup functions for the filter taps.
// ----------------------------------------------------------------------------
`default_nettype none

package gbls_pkg;

  // Fixed field widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int WEIGHT_W = 8;
  localparam int LWIDTH_W = 11;
  localparam int IDX_W   = 3;
  // 25 products of 16 x 8 bits need five more bits of headroom
  localparam int ACC_W   = COEF_W + PIX_W + 5;
  localparam int RING_LOG = 3;
  localparam int NUM_COEFS = 6;

  localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RESET = 11'd1024;
  localparam logic [COEF_W-1:0]   COEF_RESET       = 16'd2621;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 8'd1;
  localparam logic [PIX_W-1:0]    PIXEL_MAX        = 8'd255;

  localparam logic signed [2:0] TAP_FIRST = -3'sd2;
  localparam logic signed [2:0] TAP_LAST  = 3'sd2;
  localparam logic [2:0]        SEL_LAST  = 3'd4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LINE_WIDTH,
    REG_COEF_CENTER,
    REG_COEF_EDGE_ONE,
    REG_COEF_DIAG_ONE,
    REG_COEF_EDGE_TWO,
    REG_COEF_KNIGHT,
    REG_COEF_DIAG_TWO,
    REG_SHARPEN_WEIGHT
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_TAP,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_FINISH,
    ST_LAP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              accept;
    logic              centre;
    logic              tap;
    logic signed [2:0] dy;
    logic signed [2:0] dx;
    logic [2:0]        sel;
    logic              finish;
    logic              lap;
    logic              emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic produce;
    logic out_free;
  } status_t;

  // Coefficient register for a tap offset, symmetric under sign and axis swap
  function automatic logic [2:0] coef_index(input logic signed [2:0] dy,
                                            input logic signed [2:0] dx);
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] lo;
    logic [1:0] hi;
    a = dy[2] ? 2'(-dy) : dy[1:0];
    b = dx[2] ? 2'(-dx) : dx[1:0];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi == 2'd0) return 3'd0;
    if (hi == 2'd1) return (lo == 2'd0) ? 3'd1 : 3'd2;
    if (lo == 2'd0) return 3'd3;
    return (lo == 2'd1) ? 3'd4 : 3'd5;
  endfunction

  // Offsets of the five blurred values used by the Laplacian
  function automatic logic signed [2:0] centre_dy(input logic [2:0] sel);
    case (sel)
      3'd1:    return -3'sd1;
      3'd2:    return 3'sd1;
      default: return 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] centre_dx(input logic [2:0] sel);
    case (sel)
      3'd3:    return -3'sd1;
      3'd4:    return 3'sd1;
      default: return 3'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbls_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbls_ctrl: sequencer of the blur and sharpen block
// Takes one item at a time; for one that yields a result, walks the datapath
// through five blur evaluations of 25 taps each, the Laplacian and the result
// hand-over.
`default_nettype none

module gbls_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire gbls_pkg::status_t status,
  output gbls_pkg::cmd_t         cmd
);

  gbls_pkg::state_t  state, state_next;
  logic [2:0]        sel, sel_next;
  logic signed [2:0] dy, dy_next;
  logic signed [2:0] dx, dx_next;

  // State and tap counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbls_pkg::ST_IDLE;
      sel   <= 3'd0;
      dy    <= gbls_pkg::TAP_FIRST;
      dx    <= gbls_pkg::TAP_FIRST;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      dy    <= dy_next;
      dx    <= dx_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    dy_next    = dy;
    dx_next    = dx;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.dy     = dy;
    cmd.dx     = dx;
    cmd.sel    = sel;
    case (state)
      gbls_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.produce) begin
            sel_next   = 3'd0;
            state_next = gbls_pkg::ST_CENTRE;
          end
        end
      end
      gbls_pkg::ST_CENTRE: begin
        cmd.centre = 1'b1;
        dy_next    = gbls_pkg::TAP_FIRST;
        dx_next    = gbls_pkg::TAP_FIRST;
        state_next = gbls_pkg::ST_TAP;
      end
      gbls_pkg::ST_TAP: begin
        cmd.tap = 1'b1;
        if (dx == gbls_pkg::TAP_LAST) begin
          dx_next = gbls_pkg::TAP_FIRST;
          if (dy == gbls_pkg::TAP_LAST) begin
            state_next = gbls_pkg::ST_WAIT_A;
          end else begin
            dy_next = dy + 3'sd1;
          end
        end else begin
          dx_next = dx + 3'sd1;
        end
      end
      gbls_pkg::ST_WAIT_A: begin
        state_next = gbls_pkg::ST_WAIT_B;
      end
      gbls_pkg::ST_WAIT_B: begin
        state_next = gbls_pkg::ST_FINISH;
      end
      gbls_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        if (sel == gbls_pkg::SEL_LAST) begin
          state_next = gbls_pkg::ST_LAP;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = gbls_pkg::ST_CENTRE;
        end
      end
      gbls_pkg::ST_LAP: begin
        cmd.lap    = 1'b1;
        state_next = gbls_pkg::ST_EMIT;
      end
      gbls_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gbls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbls_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbls_datapath.sv =====
// ----------------------------------------------------------------------------
// gbls_datapath: storage and arithmetic of the blur and sharpen block
// Configuration registers, frame bookkeeping, the eight-row line memory,
// a multiply-accumulate unit for the blur, the Laplacian and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbls_datapath #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 4096,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire gbls_pkg::cmd_t   cmd,
  output gbls_pkg::status_t     status,
  input  wire                   action,
  input  wire [7:0]             pixel_in,
  input  wire                   frame_end,
  input  wire                   cfg_write,
  input  wire [2:0]             cfg_index,
  input  wire [15:0]            cfg_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            pixel_out,
  output logic                  last_out
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT) + 1;
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DLW  = WW + 2;
  localparam int SRW  = RW + 1;
  localparam int SCW  = CW + 2;
  localparam int AW   = gbls_pkg::ACC_W;
  localparam int MEM_DEPTH = 2 ** (gbls_pkg::RING_LOG + CW);

  // Configuration registers
  logic [gbls_pkg::LWIDTH_W-1:0] line_width;
  logic [gbls_pkg::COEF_W-1:0]   coef [gbls_pkg::NUM_COEFS];
  logic [gbls_pkg::WEIGHT_W-1:0] weight;

  // Frame bookkeeping
  logic [WW-1:0]  frame_width;
  logic [DLW-1:0] delay;
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [NW-1:0]  received;
  logic [NW-1:0]  drain_pos;
  logic           frame_done;
  logic [RW-1:0]  last_row;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  out_row;
  logic [CW-1:0]  out_col;
  logic           last_pending;

  // Line memory and filter pipeline
  logic [7:0]           line_mem [MEM_DEPTH];
  logic [7:0]           rd_pix;
  logic [15:0]          coef_q;
  logic                 tap_v1;
  logic [23:0]          prod;
  logic                 tap_v2;
  logic [AW-1:0]        acc;
  logic [RW-1:0]        ccy;
  logic [CW-1:0]        ccx;
  logic [7:0]           blur [5];
  logic [15:0]          mul_q;

  // Acceptance decode
  logic [WW-1:0]  w_lim;
  logic [DLW-1:0] d_lim;
  logic           newf;
  logic [WW-1:0]  e_width;
  logic [DLW-1:0] e_delay;
  logic [CW-1:0]  e_col;
  logic [RW-1:0]  e_row;
  logic [NW-1:0]  e_rcv;
  logic           col_at_end;
  logic           end_hit;
  logic           pix_produce;
  logic           drain_produce;

  // Tap addressing and arithmetic
  logic signed [SRW-1:0] cy_raw, ty_raw;
  logic signed [SCW-1:0] cx_raw, tx_raw;
  logic [RW-1:0]         ty;
  logic [CW-1:0]         tx;
  logic [AW-1:0]         blur_sh;
  logic [7:0]            blur_sat;
  logic signed [11:0]    lap_s;
  logic [7:0]            lap_c;
  logic signed [17:0]    diff;
  logic [7:0]            sharp;

  // Replicate the border: clamp a row to the received part of the frame
  function automatic logic [RW-1:0] clamp_row(input logic signed [SRW-1:0] y,
                                              input logic [RW-1:0] lrow);
    if (y[SRW-1]) return '0;
    if (y > $signed({1'b0, lrow})) return lrow;
    return y[RW-1:0];
  endfunction

  // Clamp a column to the row width, and to the last pixel on the last row
  function automatic logic [CW-1:0] clamp_col(input logic [RW-1:0] yc,
                                              input logic signed [SCW-1:0] x,
                                              input logic [RW-1:0] lrow,
                                              input logic [CW-1:0] lcol,
                                              input logic [WW-1:0] w);
    logic signed [SCW-1:0] wm1;
    logic signed [SCW-1:0] lc;
    logic signed [SCW-1:0] r;
    wm1 = $signed(SCW'(w) - SCW'(1));
    lc  = $signed({2'b00, lcol});
    r   = x;
    if (x[SCW-1]) r = '0;
    else if (x > wm1) r = wm1;
    if ((yc == lrow) && (r > lc)) r = lc;
    return r[CW-1:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= gbls_pkg::LINE_WIDTH_RESET;
      for (int i = 0; i < gbls_pkg::NUM_COEFS; i++) coef[i] <= gbls_pkg::COEF_RESET;
      weight <= gbls_pkg::WEIGHT_RESET;
    end else if (cfg_write) begin
      case (gbls_pkg::reg_index_t'(cfg_index))
        gbls_pkg::REG_LINE_WIDTH:     line_width <= cfg_data[gbls_pkg::LWIDTH_W-1:0];
        gbls_pkg::REG_COEF_CENTER:    coef[0] <= cfg_data;
        gbls_pkg::REG_COEF_EDGE_ONE:  coef[1] <= cfg_data;
        gbls_pkg::REG_COEF_DIAG_ONE:  coef[2] <= cfg_data;
        gbls_pkg::REG_COEF_EDGE_TWO:  coef[3] <= cfg_data;
        gbls_pkg::REG_COEF_KNIGHT:    coef[4] <= cfg_data;
        gbls_pkg::REG_COEF_DIAG_TWO:  coef[5] <= cfg_data;
        gbls_pkg::REG_SHARPEN_WEIGHT: weight <= cfg_data[gbls_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Width in use for a new frame and the output delay that follows from it
  always_comb begin
    if (line_width == '0) w_lim = WW'(1);
    else if (int'(line_width) > MAX_WIDTH) w_lim = WW'(MAX_WIDTH);
    else w_lim = WW'(line_width);
    d_lim = DLW'({w_lim, 1'b0}) + DLW'(w_lim)
          + ((w_lim > WW'(3)) ? DLW'(3) : DLW'(w_lim - WW'(1)));
  end

  // A pixel after a finished frame, or the very first pixel, opens a frame
  assign newf    = frame_done || (received == '0);
  assign e_width = newf ? w_lim : frame_width;
  assign e_delay = newf ? d_lim : delay;
  assign e_col   = newf ? '0 : column_count;
  assign e_row   = newf ? '0 : row_count;
  assign e_rcv   = newf ? '0 : received;

  assign col_at_end    = (WW'(e_col) + WW'(1)) == e_width;
  assign end_hit       = frame_end || ((e_row == RW'(MAX_HEIGHT - 1)) && col_at_end);
  assign pix_produce   = e_rcv >= NW'(e_delay);
  assign drain_produce = (received != '0) && frame_done && (drain_pos < received);

  assign status.produce  = action ? drain_produce : pix_produce;
  assign status.out_free = !out_valid || out_ready;

  // Frame bookkeeping and the output position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WW'(1);
      delay        <= DLW'(3);
      column_count <= '0;
      row_count    <= '0;
      received     <= '0;
      drain_pos    <= '0;
      frame_done   <= 1'b0;
      last_row     <= '0;
      last_col     <= '0;
      out_row      <= '0;
      out_col      <= '0;
      last_pending <= 1'b0;
    end else if (cmd.accept) begin
      if (!action) begin
        frame_width  <= e_width;
        delay        <= e_delay;
        received     <= e_rcv + NW'(1);
        last_row     <= e_row;
        last_col     <= e_col;
        frame_done   <= end_hit;
        last_pending <= 1'b0;
        if (col_at_end) begin
          column_count <= '0;
          row_count    <= e_row + RW'(1);
        end else begin
          column_count <= e_col + CW'(1);
          row_count    <= e_row;
        end
        if (newf) begin
          drain_pos <= '0;
          out_row   <= '0;
          out_col   <= '0;
        end
      end else begin
        last_pending <= (drain_pos == (received - NW'(1)));
      end
    end else if (cmd.emit) begin
      drain_pos <= drain_pos + NW'(1);
      if ((WW'(out_col) + WW'(1)) == frame_width) begin
        out_col <= '0;
        out_row <= out_row + RW'(1);
      end else begin
        out_col <= out_col + CW'(1);
      end
    end
  end

  // Line memory write of each frame pixel
  always_ff @(posedge clk) begin
    if (cmd.accept && !action) begin
      line_mem[{e_row[gbls_pkg::RING_LOG-1:0], e_col}] <= pixel_in;
    end
  end

  // Centre of the current blur evaluation, clamped to the frame
  assign cy_raw = $signed({1'b0, out_row}) + SRW'(gbls_pkg::centre_dy(cmd.sel));
  assign cx_raw = $signed({2'b00, out_col}) + SCW'(gbls_pkg::centre_dx(cmd.sel));

  // Tap position around the clamped centre
  assign ty_raw = $signed({1'b0, ccy}) + SRW'(cmd.dy);
  assign tx_raw = $signed({2'b00, ccx}) + SCW'(cmd.dx);
  assign ty     = clamp_row(ty_raw, last_row);
  assign tx     = clamp_col(ty, tx_raw, last_row, last_col, frame_width);

  always_ff @(posedge clk) begin
    if (cmd.centre) begin
      ccy <= clamp_row(cy_raw, last_row);
      ccx <= clamp_col(clamp_row(cy_raw, last_row), cx_raw, last_row, last_col,
                       frame_width);
    end
  end

  // Tap read, multiply and accumulate
  always_ff @(posedge clk) begin
    if (cmd.tap) begin
      rd_pix <= line_mem[{ty[gbls_pkg::RING_LOG-1:0], tx}];
      coef_q <= coef[gbls_pkg::coef_index(cmd.dy, cmd.dx)];
    end
    prod <= coef_q * rd_pix;
    if (cmd.centre) acc <= '0;
    else if (tap_v2) acc <= acc + AW'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_v1 <= 1'b0;
      tap_v2 <= 1'b0;
    end else begin
      tap_v1 <= cmd.tap;
      tap_v2 <= tap_v1;
    end
  end

  // Scale the blur sum down and saturate it
  assign blur_sh  = acc >> COEF_FRAC_BITS;
  assign blur_sat = (blur_sh > AW'(255)) ? gbls_pkg::PIXEL_MAX : blur_sh[7:0];

  always_ff @(posedge clk) begin
    if (cmd.finish) blur[cmd.sel] <= blur_sat;
  end

  // Laplacian of the blurred image, clamped, times the sharpening weight
  assign lap_s = $signed({4'b0, blur[1]}) + $signed({4'b0, blur[2]})
               + $signed({4'b0, blur[3]}) + $signed({4'b0, blur[4]})
               - $signed({2'b0, blur[0], 2'b00});
  assign lap_c = lap_s[11] ? 8'd0
               : ((lap_s > 12'sd255) ? gbls_pkg::PIXEL_MAX : lap_s[7:0]);

  always_ff @(posedge clk) begin
    if (cmd.lap) mul_q <= weight * lap_c;
  end

  // Sharpened value and the result register
  assign diff  = $signed({10'b0, blur[0]}) - $signed({2'b00, mul_q});
  assign sharp = diff[17] ? 8'd0
               : ((diff > 18'sd255) ? gbls_pkg::PIXEL_MAX : diff[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_out <= sharp;
      last_out  <= last_pending;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_blur_laplacian_sharpen.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_laplacian_sharpen: 5x5 Gaussian blur followed by Laplacian
// sharpening of an 8-bit grayscale raster stream
// ----------------------------------------------------------------------------
// The block takes one item at a time. An item that yields no result (an early
// pixel of a frame, or an idle drain tick) leaves the controller idle. An item
// that yields a result holds the input side until its result is loaded: five
// blurred values are formed, each by a clamping step, reads of 25 taps from
// the line memory into one 16 x 8 multiply-accumulate unit and a pipeline
// drain; then the Laplacian product is formed and the result register is
// loaded. That result register lets the next item in while the previous
// result still waits on the output; a later result then waits in its hand-over
// state until the register is free. Frame pixels carry tuser = 0 and tlast on
// the frame's last pixel; drain ticks (tuser = 1) flush the pending results
// after the frame has ended. The user must write configuration on the cfg
// channel only while the block is idle; the block does not enforce this.
`default_nettype none

module gaussian_blur_laplacian_sharpen #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 4096,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] pixel_in
  input  wire         s_tuser,   // [0] action: 0 frame pixel, 1 drain tick
  input  wire         s_tlast,   // frame_end
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [7:0] pixel_out
  output logic        m_tlast,   // last_out
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  gbls_pkg::cmd_t    cmd;
  gbls_pkg::status_t status;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  // Controller
  gbls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  gbls_datapath #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .action    (s_tuser),
    .pixel_in  (s_tdata),
    .frame_end (s_tlast),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pixel_out (m_tdata),
    .last_out  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gbls_checker.sv =====
// ----------------------------------------------------------------------------
// gbls_checker: port-level checks of the blur and sharpen block
// Watches the stream and configuration ports over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbls_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata,
  input wire        m_tlast,
  input wire        cfg_valid,
  input wire        cfg_ready
);

  // A stalled result transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // A result is only loaded after the input side has been busy computing it
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready) && !$past(s_tready, 2))
    else $error("result appeared without a computation");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Configuration writes are never refused
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration transaction refused");

endmodule

bind gaussian_blur_laplacian_sharpen gbls_checker u_gbls_checker (.*);

`default_nettype wire
